>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with reset disable, used by mrg_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRG_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mrg_pkg.sv
// ----------------------------------------------------------------------------
// mrg_pkg
// Types, write tables and value selection for the matmul command generator.
// ----------------------------------------------------------------------------
package mrg_pkg;

  localparam int unsigned NUM_WRITES = 21;
  localparam int unsigned IDX_W      = $clog2(NUM_WRITES);

  typedef logic [IDX_W-1:0] wr_idx_t;

  // Write positions in emission order
  localparam wr_idx_t W_KDIM     = wr_idx_t'(0);
  localparam wr_idx_t W_KN2      = wr_idx_t'(1);
  localparam wr_idx_t W_K2       = wr_idx_t'(2);
  localparam wr_idx_t W_K32      = wr_idx_t'(3);
  localparam wr_idx_t W_K        = wr_idx_t'(4);
  localparam wr_idx_t W_K8       = wr_idx_t'(5);
  localparam wr_idx_t W_M_A      = wr_idx_t'(6);
  localparam wr_idx_t W_M_B      = wr_idx_t'(7);
  localparam wr_idx_t W_M        = wr_idx_t'(8);
  localparam wr_idx_t W_ROWS     = wr_idx_t'(9);
  localparam wr_idx_t W_M1       = wr_idx_t'(10);
  localparam wr_idx_t W_M1_SH    = wr_idx_t'(11);
  localparam wr_idx_t W_M1_SH_B  = wr_idx_t'(12);
  localparam wr_idx_t W_N1_PAIR  = wr_idx_t'(13);
  localparam wr_idx_t W_N1       = wr_idx_t'(14);
  localparam wr_idx_t W_NQ1_PAIR = wr_idx_t'(15);
  localparam wr_idx_t W_N_FLAG   = wr_idx_t'(16);
  localparam wr_idx_t W_N1_B     = wr_idx_t'(17);
  localparam wr_idx_t W_A_FEAT   = wr_idx_t'(18);
  localparam wr_idx_t W_A_WGT    = wr_idx_t'(19);
  localparam wr_idx_t W_A_OUT    = wr_idx_t'(20);
  localparam wr_idx_t LAST_IDX   = W_A_OUT;

  localparam logic [15:0] BLK_CORE = 16'h0201;
  localparam logic [15:0] BLK_PE   = 16'h1001;
  localparam logic [15:0] BLK_WB   = 16'h0801;

  localparam logic [15:0] WR_BLOCK [NUM_WRITES] = '{
    BLK_CORE, BLK_CORE, BLK_CORE, BLK_CORE, BLK_CORE, BLK_CORE,
    BLK_CORE, BLK_CORE, BLK_CORE, BLK_CORE,
    BLK_PE,   BLK_PE,   BLK_WB,
    BLK_PE,   BLK_PE,   BLK_PE,   BLK_CORE, BLK_WB,
    BLK_CORE, BLK_CORE, BLK_PE
  };

  localparam logic [15:0] WR_OFFSET [NUM_WRITES] = '{
    16'h1024, 16'h1030, 16'h1034, 16'h1044, 16'h1088, 16'h107c,
    16'h1020, 16'h1084, 16'h102c, 16'h1010,
    16'h4034, 16'h405c, 16'h3014,
    16'h403c, 16'h4058, 16'h4038, 16'h1038, 16'h3018,
    16'h1070, 16'h1110, 16'h4020
  };

  localparam logic [11:0] ROW_SAT   = 12'h800;
  localparam logic [13:0] ROW_SAT_M = 14'd127;
  localparam logic [31:0] N_FLAG    = 32'h0101_0000;
  localparam logic [31:0] M_FLAG    = 32'h0001_0000;

  typedef struct packed {
    logic [13:0] rows_m;
    logic [8:0]  k_tiles;
    logic [9:0]  n_tiles;
    logic [31:0] addr_feature;
    logic [31:0] addr_weight;
    logic [31:0] addr_output;
  } mrg_in_t;

  typedef struct packed {
    logic [15:0] reg_block;
    logic [15:0] reg_offset;
    logic [31:0] reg_value;
    logic [31:0] cmd_word_low;
    logic [31:0] cmd_word_high;
    logic        last_entry;
  } mrg_out_t;

  // Per-job values prepared once, ahead of the write sequence
  typedef struct packed {
    logic [8:0]  kt;
    logic [15:0] km1;
    logic [18:0] kn;
    logic [13:0] m;
    logic [11:0] rows;
    logic [31:0] m1;
    logic [13:0] n;
    logic [31:0] n1;
    logic [15:0] nq1;
    logic [31:0] addr_feature;
    logic [31:0] addr_weight;
    logic [31:0] addr_output;
  } mrg_job_t;

  typedef struct packed {
    wr_idx_t     idx;
    logic [31:0] value;
  } mrg_ent_t;

  function automatic logic [31:0] wr_value(wr_idx_t idx, mrg_job_t j);
    logic [13:0] k;
    logic [31:0] v;
    k = {j.kt, 5'b0};
    case (idx)
      W_KDIM:                v = {j.km1, 2'b0, k};
      W_KN2:                 v = {3'b0, j.kn, 10'b0};
      W_K2:                  v = {17'b0, j.kt, 6'b0};
      W_K32:                 v = {23'b0, j.kt};
      W_K:                   v = {18'b0, k};
      W_K8:                  v = {21'b0, j.kt, 2'b0};
      W_M_A, W_M_B:          v = M_FLAG | {18'b0, j.m};
      W_M:                   v = {18'b0, j.m};
      W_ROWS:                v = {20'b0, j.rows};
      W_M1:                  v = j.m1;
      W_M1_SH, W_M1_SH_B:    v = {j.m1[15:0], 16'b0};
      W_N1_PAIR:             v = {j.n1[15:0], j.n1[15:0]};
      W_N1, W_N1_B:          v = j.n1;
      W_NQ1_PAIR:            v = {j.nq1, j.nq1};
      W_N_FLAG:              v = N_FLAG | {18'b0, j.n};
      W_A_FEAT:              v = j.addr_feature;
      W_A_WGT:               v = j.addr_weight;
      W_A_OUT:               v = j.addr_output;
      default:               v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/matmul_regcmd_generator.sv
// ----------------------------------------------------------------------------
// matmul_regcmd_generator
// Turns one matmul job into its 21 dimension-dependent register writes.
// ----------------------------------------------------------------------------
// Path: input stage register, write sequencer with its entry register, output register.
// Throughput: one write per cycle while the output is not stalled. The next
//   job waits in the input stage until the write sequencer takes it.
// Reset: asynchronous, active low; clears all valid bits and the sequencer.
module matmul_regcmd_generator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mrg_pkg::mrg_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mrg_pkg::mrg_out_t out_data_o
);
  import mrg_pkg::*;

  logic     job_valid;
  mrg_job_t job;
  logic     take;
  logic     ent_valid;
  mrg_ent_t ent;
  logic     ent_stall;

  mrg_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .take_i      (take),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  mrg_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .take_o      (take),
    .ent_valid_o (ent_valid),
    .ent_o       (ent),
    .ent_stall_i (ent_stall)
  );

  mrg_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (ent_valid),
    .ent_i       (ent),
    .ent_stall_o (ent_stall),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> rtl/mrg_calc.sv
// ----------------------------------------------------------------------------
// mrg_calc
// Job input stage: registers one job with its derived dimension values.
// ----------------------------------------------------------------------------
module mrg_calc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mrg_pkg::mrg_in_t  in_data_i,
  input  logic              take_i,
  output logic              job_valid_o,
  output mrg_pkg::mrg_job_t job_o
);
  import mrg_pkg::*;

  logic     valid_q, valid_d;
  mrg_job_t job_q, job_d;
  logic     load;
  logic [13:0] k;
  logic [13:0] n;
  logic [7:0]  m_inc;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    k     = {in_data_i.k_tiles, 5'b0};
    n     = {in_data_i.n_tiles, 4'b0};
    m_inc = {1'b0, in_data_i.rows_m[6:0]} + 8'd1;

    job_d.kt   = in_data_i.k_tiles;
    job_d.km1  = {2'b0, k} - 16'd1;
    job_d.kn   = 19'(in_data_i.k_tiles) * 19'(in_data_i.n_tiles);
    job_d.m    = in_data_i.rows_m;
    // 16*(M+1) saturates once M passes 127
    job_d.rows = (in_data_i.rows_m > ROW_SAT_M) ? ROW_SAT : {m_inc, 4'b0};
    job_d.m1   = {18'b0, in_data_i.rows_m} - 32'd1;
    job_d.n    = n;
    job_d.n1   = {18'b0, n} - 32'd1;
    job_d.nq1  = {4'b0, in_data_i.n_tiles, 2'b0} - 16'd1;
    job_d.addr_feature = in_data_i.addr_feature;
    job_d.addr_weight  = in_data_i.addr_weight;
    job_d.addr_output  = in_data_i.addr_output;
  end

  always_comb begin
    valid_d = valid_q;
    if (take_i) valid_d = 1'b0;
    if (load)   valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

>>> rtl/mrg_seq.sv
// ----------------------------------------------------------------------------
// mrg_seq
// Write sequencer: steps through the 21 writes of the held job, one a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module mrg_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  mrg_pkg::mrg_job_t job_i,
  output logic              take_o,
  output logic              ent_valid_o,
  output mrg_pkg::mrg_ent_t ent_o,
  input  logic              ent_stall_i
);
  import mrg_pkg::*;

  logic     busy_q, busy_d;
  wr_idx_t  cnt_q, cnt_d;
  mrg_job_t job_q;
  logic     ent_valid_q, ent_valid_d;
  mrg_ent_t ent_q;
  logic     ent_free;
  logic     emit;
  logic     last;

  assign ent_free = !ent_valid_q || !ent_stall_i;
  assign emit     = busy_q && ent_free;
  assign last     = (cnt_q == LAST_IDX);
  // Pick up the next job in the same cycle the last write leaves
  assign take_o   = job_valid_i && (!busy_q || (emit && last));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (emit) begin
      cnt_d = cnt_q + wr_idx_t'(1);
      if (last) busy_d = 1'b0;
    end
    if (take_o) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_comb begin
    ent_valid_d = ent_valid_q;
    if (ent_free) ent_valid_d = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      ent_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      ent_valid_q <= ent_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      ent_q.idx   <= cnt_q;
      ent_q.value <= wr_value(cnt_q, job_q);
    end
  end

  assign ent_valid_o = ent_valid_q;
  assign ent_o       = ent_q;

endmodule

>>> rtl/mrg_pack.sv
// ----------------------------------------------------------------------------
// mrg_pack
// Output stage: adds block and offset, packs the two command words.
// ----------------------------------------------------------------------------
module mrg_pack (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ent_valid_i,
  input  mrg_pkg::mrg_ent_t  ent_i,
  output logic               ent_stall_o,
  output logic               out_valid_o,
  output mrg_pkg::mrg_out_t  out_data_o,
  input  logic               out_stall_i
);
  import mrg_pkg::*;

  logic     valid_q, valid_d;
  mrg_out_t data_q, data_d;
  logic     free;
  logic     load;

  assign free        = !valid_q || !out_stall_i;
  assign ent_stall_o = !free;
  assign load        = free && ent_valid_i;

  always_comb begin
    data_d.reg_block     = WR_BLOCK[ent_i.idx];
    data_d.reg_offset    = WR_OFFSET[ent_i.idx];
    data_d.reg_value     = ent_i.value;
    data_d.cmd_word_low  = {ent_i.value[15:0], data_d.reg_offset};
    data_d.cmd_word_high = {data_d.reg_block, ent_i.value[31:16]};
    data_d.last_entry    = (ent_i.idx == LAST_IDX);
  end

  always_comb begin
    valid_d = valid_q;
    if (free) valid_d = ent_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

>>> rtl/mrg_checker.sv
// ----------------------------------------------------------------------------
// mrg_checker
// Port-level checks of the command generator: job framing and occupancy.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input mrg_pkg::mrg_out_t out_data_o
);
  import mrg_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic       job_done;
  wr_idx_t    cnt_q, cnt_d;
  logic [2:0] pend_q, pend_d;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign job_done = out_acc && out_data_o.last_entry;

  always_comb begin
    cnt_d = cnt_q;
    if (out_acc) cnt_d = (cnt_q == LAST_IDX) ? '0 : cnt_q + wr_idx_t'(1);
    pend_d = pend_q + {2'b0, in_acc} - {2'b0, job_done};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  `MRG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output item changed")
  `MRG_ASSERT(a_last_frame, clk_i, rst_ni, out_acc, out_data_o.last_entry == (cnt_q == LAST_IDX), "last flag off the 21-write frame")
  `MRG_ASSERT(a_no_orphan, clk_i, rst_ni, out_valid_o, pend_q != 3'd0, "output item without an open job")
  `MRG_ASSERT(a_occupancy, clk_i, rst_ni, 1'b1, pend_q <= 3'd4, "more jobs in flight than the stages hold")

endmodule

bind matmul_regcmd_generator mrg_checker u_mrg_checker (.*);
